### hw/rtl/tfm_pkg.sv
// Shared constants, types and register map of the topic filter matcher.
`timescale 1ns / 1ps

package tfm_pkg;

   // Filter storage size and derived widths
   localparam int FILTER_MAX    = 32;
   localparam int CHAR_W        = 8;
   localparam int POS_W         = 6;
   localparam int IDX_W         = $clog2(FILTER_MAX);
   localparam int CSR_W         = 64;
   localparam int NUM_CHAR_REGS = FILTER_MAX * CHAR_W / CSR_W;
   localparam int CHAR_REG_W    = $clog2(NUM_CHAR_REGS);
   localparam int CSR_IDX_W     = 3;
   localparam int LEN_W         = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHARS_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH  = 3'd4;

   // Special characters
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;

   typedef enum logic [1:0] {
      VERDICT_UNDECIDED,
      VERDICT_MATCH,
      VERDICT_FAIL
   } verdict_type;

   typedef logic [FILTER_MAX-1:0][CHAR_W-1:0] filter_chars_type;

   // Per-topic match state
   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             skipping;
      logic             sep_passed;
      logic             plain;
      logic             first;
      verdict_type      verdict;
   } tfm_state_type;

   localparam tfm_state_type STATE_CLEAR = '{
      pos:        '0,
      skipping:   1'b0,
      sep_passed: 1'b0,
      plain:      1'b0,
      first:      1'b1,
      verdict:    VERDICT_UNDECIDED
   };

endpackage

### hw/rtl/tfm_step.sv
// Next-state logic for one topic character, plus the verdict on a terminator.
`timescale 1ns / 1ps

module tfm_step (
   input  tfm_pkg::tfm_state_type    cur_st,
   input  logic [7:0]                topic_char,
   input  tfm_pkg::filter_chars_type chars,
   input  logic [5:0]                len,
   output tfm_pkg::tfm_state_type    nxt_st,
   output logic                      matched
);
   import tfm_pkg::*;

   logic [FILTER_MAX-1:0] run_mask;
   logic [IDX_W-1:0]      run_idx;
   logic                  run_found;
   logic [CHAR_W-1:0]     run_char;
   logic [CHAR_W-1:0]     fch;
   logic                  plain_n;
   logic                  wild;

   // Find the first non-plus filter char at or after the position, inside the length
   always_comb begin
      run_idx = '0;
      for (int i = 0; i < FILTER_MAX; i++) begin
         run_mask[i] = (chars[i] != CH_PLUS) && (POS_W'(i) >= cur_st.pos) &&
                       (POS_W'(i) < len);
      end
      for (int i = FILTER_MAX - 1; i >= 0; i--) begin
         if (run_mask[i]) begin
            run_idx = IDX_W'(i);
         end
      end
   end

   assign run_found = |run_mask;
   assign run_char  = chars[run_idx];
   assign fch       = chars[cur_st.pos[IDX_W-1:0]];
   assign plain_n   = cur_st.first ? (topic_char != CH_DOLLAR) : cur_st.plain;
   assign wild      = plain_n | cur_st.sep_passed;

   // One character step
   always_comb begin
      nxt_st = cur_st;
      if (cur_st.verdict == VERDICT_UNDECIDED) begin
         nxt_st.plain = plain_n;
         nxt_st.first = 1'b0;
         if (!cur_st.skipping || topic_char == CH_SLASH) begin
            nxt_st.skipping = 1'b0;
            if (cur_st.pos >= len) begin
               nxt_st.verdict = VERDICT_FAIL;
            end else if (fch == CH_PLUS && wild) begin
               nxt_st.sep_passed = 1'b1;
               if (topic_char != CH_SLASH) begin
                  // plus eats the rest of this level
                  nxt_st.pos      = cur_st.pos + POS_W'(1);
                  nxt_st.skipping = 1'b1;
               end else if (!run_found) begin
                  nxt_st.verdict = VERDICT_FAIL;
               end else if (run_char == CH_HASH) begin
                  nxt_st.verdict = VERDICT_MATCH;
               end else if (run_char == CH_SLASH) begin
                  nxt_st.pos = POS_W'(run_idx) + POS_W'(1);
               end else begin
                  nxt_st.verdict = VERDICT_FAIL;
               end
            end else if (fch == CH_HASH && wild) begin
               nxt_st.verdict = VERDICT_MATCH;
            end else if (topic_char != fch) begin
               nxt_st.verdict = VERDICT_FAIL;
            end else begin
               if (fch == CH_SLASH) begin
                  nxt_st.sep_passed = 1'b1;
               end
               nxt_st.pos = cur_st.pos + POS_W'(1);
            end
         end
      end
   end

   // Verdict on terminator: undecided matches only if the filter is used up
   always_comb begin
      unique case (cur_st.verdict)
         VERDICT_MATCH:     matched = 1'b1;
         VERDICT_FAIL:      matched = 1'b0;
         VERDICT_UNDECIDED: matched = (cur_st.pos >= len);
         default:           matched = 1'b0;
      endcase
   end

endmodule

### hw/rtl/topic_filter_matcher.sv
// Top level of the topic filter matcher: input stage, match state, result register.
//
//   channel  | dir | handshake             | payload
//   ---------+-----+-----------------------+------------------------------------
//   req_     | in  | tvalid / tready       | tdata[7:0] topic_char, tlast end_of_topic
//   rsp_     | out | tvalid / tready       | tdata[0] matched, tdata[7:1] zero
//   csr_     | in  | we, no wait           | index[2:0], wdata[63:0]
//
// One item per cycle sustained while no result is stalled; a terminator's result passes
// through the input register, then the result register.
// The match state is registered, computed from the input register and the filter.
// Reset is synchronous and clears the filter, length and match state at once.
// A stalled result holds a terminator in the input register, and every later
// item waits behind it; characters ahead of that terminator keep flowing.
`timescale 1ns / 1ps

module topic_filter_matcher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] topic_char
   input  logic        req_tlast,   // end_of_topic
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] matched, [7:1] zero
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import tfm_pkg::*;

   logic [NUM_CHAR_REGS-1:0][CSR_W-1:0] filter_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [LEN_W-1:0]  len_used;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   tfm_state_type     state_ff, state_in, step_st;
   logic              step_matched;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_matched_ff;

   logic              req_take;
   logic              out_free;
   logic              in_go;
   filter_chars_type  chars;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
         length_ff <= '0;
      end else if (csr_we) begin
         priority if (csr_index == REG_LENGTH) begin
            length_ff <= csr_wdata[LEN_W-1:0];
         end else if (csr_index < CSR_IDX_W'(NUM_CHAR_REGS)) begin
            filter_ff[csr_index[CHAR_REG_W-1:0]] <= csr_wdata;
         end
      end
   end

   assign chars    = filter_ff;
   assign len_used = (length_ff > LEN_W'(FILTER_MAX)) ? LEN_W'(FILTER_MAX) : length_ff;

   // Handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign in_go      = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || in_go;
   assign req_take   = req_tvalid && req_tready;

   tfm_step u_step (
      .cur_st     (state_ff),
      .topic_char (in_char_ff),
      .chars      (chars),
      .len        (len_used),
      .nxt_st     (step_st),
      .matched    (step_matched)
   );

   // Next values
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (in_go ? 1'b0 : in_valid_ff);
      state_in     = state_ff;
      if (in_go) begin
         state_in = in_last_ff ? STATE_CLEAR : step_st;
      end
      rsp_valid_in = (in_go && in_last_ff) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (in_go && in_last_ff) begin
         rsp_matched_ff <= step_matched;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_matched_ff};

endmodule

### hw/rtl/tfm_checker.sv
// Port-level checks for the topic filter matcher, bound to the top level.
`timescale 1ns / 1ps

module tfm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tlast,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only the verdict bit carries data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'b0)
      else $error("result padding not zero");

   // A fresh result follows a terminator taken at the request port
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without terminator");

   // Nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind topic_filter_matcher tfm_checker u_tfm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### dv/testbench.sv
// Self-checking testbench for the topic filter matcher: driver, match predictor and monitor.
`timescale 1ns / 1ps

module testbench;
   import tfm_pkg::*;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // Block ports
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] topic_char
   logic        req_tlast  = 1'b0; // end_of_topic
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [0] matched, [7:1] zero
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [63:0] csr_wdata  = '0;

   topic_filter_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Stimulus and scoreboard storage
   req_item_type pending_items[$];
   logic         expected_matches[$];
   req_item_type cur_item = '0;
   logic         drv_busy = 1'b0;
   logic         want_match;

   // Idle and stall control; the hold-off countdown lives in the receiver process
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   logic hold_req      = 1'b0;
   logic hold_taken    = 1'b0;
   int  hold_left      = 0;

   // Counters
   int error_count     = 0;
   int results_checked = 0;
   int items_accepted  = 0;
   int topics_sent     = 0;
   int items_queued    = 0;
   int filter_loads    = 0;

   // Predictor copy of the filter registers and match state
   logic [63:0] flt_reg [4] = '{default: '0};
   logic [5:0]  flt_len     = '0;
   logic [5:0]  m_pos       = '0;
   logic        m_skip      = 1'b0;
   logic        m_sep       = 1'b0;
   logic        m_plain     = 1'b0;
   logic        m_first     = 1'b1;
   verdict_type m_verdict   = VERDICT_UNDECIDED;

   // Filter under construction for the stimulus generator
   logic [7:0] flt_bytes [32];
   int         flt_n = 0;

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // Length in use: anything above the storage size counts as full
   function automatic logic [5:0] length_in_use();
      return (flt_len > FILTER_MAX) ? 6'(FILTER_MAX) : flt_len;
   endfunction

   function automatic logic [7:0] filter_byte(input logic [5:0] i);
      logic [4:0] k;
      k = i[4:0];
      return flt_reg[k[4:3]][k[2:0]*8 +: 8];
   endfunction

   // Advance the match state by one topic character
   task automatic match_char(input logic [7:0] c);
      logic [7:0] f;
      logic       wild;
      if (m_verdict != VERDICT_UNDECIDED) return;
      if (m_first) begin
         m_plain = (c != CH_DOLLAR);
         m_first = 1'b0;
      end
      if (m_skip) begin
         if (c != CH_SLASH) return;
         m_skip = 1'b0;
      end
      forever begin
         wild = m_plain || m_sep;
         if (m_pos >= length_in_use()) begin
            m_verdict = VERDICT_FAIL;
            return;
         end
         f = filter_byte(m_pos);
         if (f == CH_PLUS && wild) begin
            // plus eats the level; a slash lets a following plus act too
            m_pos = m_pos + 6'd1;
            m_sep = 1'b1;
            if (c != CH_SLASH) begin
               m_skip = 1'b1;
               return;
            end
            continue;
         end
         if (f == CH_HASH && wild) begin
            m_verdict = VERDICT_MATCH;
            return;
         end
         if (c != f) begin
            m_verdict = VERDICT_FAIL;
            return;
         end
         if (f == CH_SLASH) m_sep = 1'b1;
         m_pos = m_pos + 6'd1;
         return;
      end
   endtask

   // Terminator: queue the verdict and clear the topic state
   task automatic close_topic();
      logic m;
      if (m_verdict == VERDICT_MATCH) m = 1'b1;
      else if (m_verdict == VERDICT_FAIL) m = 1'b0;
      else m = (m_pos >= length_in_use());
      expected_matches.insert(expected_matches.size(), m);
      m_pos     = '0;
      m_skip    = 1'b0;
      m_sep     = 1'b0;
      m_plain   = 1'b0;
      m_first   = 1'b1;
      m_verdict = VERDICT_UNDECIDED;
   endtask

   // Driver: offers queued items, predicts on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         drv_busy = 1'b0;
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_item.last) begin
               close_topic();
               topics_sent++;
            end else begin
               match_char(cur_item.ch);
            end
            items_accepted++;
            drv_busy = 1'b0;
         end
         if (!drv_busy && pending_items.size() != 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            cur_item = pending_items.pop_front();
            drv_busy = 1'b1;
         end
         req_tvalid <= drv_busy;
         req_tdata  <= cur_item.ch;
         req_tlast  <= cur_item.last;
      end
   end

   // Receiver ready, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_req && !hold_taken) begin
            hold_left  = 300;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matches.size() == 0) begin
            report_mismatch($sformatf("result %02h with no topic closed", rsp_tdata));
         end else begin
            want_match = expected_matches.pop_front();
            if (rsp_tdata[0] !== want_match)
               report_mismatch($sformatf("matched %b, expected %b", rsp_tdata[0], want_match));
            if (rsp_tdata[7:1] !== 7'd0)
               report_mismatch($sformatf("padding bits %b not zero", rsp_tdata[7:1]));
            results_checked++;
         end
      end
   end

   // Stimulus helpers
   task automatic enqueue_item(input req_item_type it);
      pending_items.insert(pending_items.size(), it);
      items_queued++;
   endtask

   task automatic queue_byte(input logic [7:0] c);
      enqueue_item(req_item_type'{ch: c, last: 1'b0});
   endtask

   task automatic queue_end();
      enqueue_item(req_item_type'{ch: 8'($urandom_range(255)), last: 1'b1});
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) queue_byte(s[i]);
   endtask

   // Wait until every item is taken and every result is back, then let it settle
   task automatic wait_idle();
      while (drv_busy || pending_items.size() != 0 || expected_matches.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_LENGTH) flt_len = value[5:0];
      else flt_reg[idx[1:0]] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] filter_word(input int r);
      logic [63:0] w;
      int b;
      for (b = 0; b < 8; b++) w[b*8 +: 8] = flt_bytes[r*8 + b];
      return w;
   endfunction

   task automatic load_filter(input logic [5:0] len_value);
      write_reg(REG_CHARS_A, filter_word(0));
      write_reg(REG_CHARS_B, filter_word(1));
      write_reg(REG_CHARS_C, filter_word(2));
      write_reg(REG_CHARS_D, filter_word(3));
      write_reg(REG_LENGTH, 64'(len_value));
      filter_loads++;
   endtask

   task automatic set_filter_text(input string s);
      int i;
      for (i = 0; i < 32; i++) flt_bytes[i] = (i < s.len()) ? s[i] : 8'h00;
      flt_n = s.len();
   endtask

   task automatic add_filter_char(input logic [7:0] c);
      if (flt_n < 32) begin
         flt_bytes[flt_n] = c;
         flt_n++;
      end
   endtask

   function automatic logic [7:0] letter();
      return 8'h61 + 8'($urandom_range(2));
   endfunction

   function automatic logic [7:0] pick_char();
      case ($urandom_range(11))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return CH_PLUS;
         3:       return CH_HASH;
         4:       return CH_DOLLAR;
         5:       return CH_SLASH;
         default: return letter();
      endcase
   endfunction

   // Random filter: levels of plain text, plus runs and hashes; sometimes raw bytes
   task automatic build_filter();
      int i;
      int levels;
      int r;
      logic [5:0] len_value;
      for (i = 0; i < 32; i++) flt_bytes[i] = 8'($urandom_range(255));
      flt_n = 0;
      if ($urandom_range(9) == 0) begin
         flt_n = $urandom_range(0, 32);
         for (i = 0; i < flt_n; i++) flt_bytes[i] = pick_char();
      end else begin
         if ($urandom_range(7) == 0) add_filter_char(CH_DOLLAR);
         levels = $urandom_range(1, 5);
         for (i = 0; i < levels; i++) begin
            if (i > 0) add_filter_char(CH_SLASH);
            r = $urandom_range(9);
            if (r < 3) begin
               add_filter_char(CH_PLUS);
               if (r == 0) add_filter_char(CH_PLUS);
            end else if (r == 3) begin
               add_filter_char(CH_HASH);
            end else begin
               repeat ($urandom_range(0, 3)) add_filter_char(letter());
            end
         end
      end
      // length register: mostly the real length, sometimes short or oversized
      r = $urandom_range(99);
      if (r < 70) len_value = 6'(flt_n);
      else if (r < 80) len_value = 6'($urandom_range(0, 32));
      else if (r < 87) len_value = 6'd32;
      else if (r < 94) len_value = 6'd63;
      else len_value = 6'($urandom_range(33, 62));
      load_filter(len_value);
   endtask

   // Random topic: mostly shaped after the filter, with noise and broken ones
   task automatic queue_topic();
      int k;
      int stop_at;
      logic [7:0] b;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(0, 12)) queue_byte(8'($urandom_range(255)));
      end else begin
         stop_at = ($urandom_range(7) == 0) ? $urandom_range(0, flt_n) : flt_n;
         if ($urandom_range(9) == 0) queue_byte(CH_DOLLAR);
         for (k = 0; k < stop_at; k++) begin
            b = flt_bytes[k];
            if (b == CH_PLUS && $urandom_range(3) != 0) begin
               repeat ($urandom_range(0, 3)) queue_byte(letter());
            end else if (b == CH_HASH && $urandom_range(3) != 0) begin
               repeat ($urandom_range(0, 3)) queue_byte(letter());
               if ($urandom_range(1) == 0) begin
                  queue_byte(CH_SLASH);
                  repeat ($urandom_range(0, 2)) queue_byte(letter());
               end
            end else begin
               queue_byte(b);
            end
            if ($urandom_range(29) == 0) queue_byte(pick_char());
         end
         if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 4)) queue_byte(pick_char());
      end
      queue_end();
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      int target;
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
      build_filter();
      target = items_queued + count;
      while (items_queued < target) begin
         if ($urandom_range(9) == 0) begin
            wait_idle();
            build_filter();
         end
         queue_topic();
      end
      wait_idle();
   endtask

   // Run limit
   initial begin
      #400000;
      $display("topic_filter_matcher verification failed");
      $finish;
   end

   // Main sequence
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty filter after reset: empty topic matches, any character fails
      queue_end();
      queue_text("a");
      queue_end();
      wait_idle();

      // Plus run and trailing hash; hash at topic end; dollar topic; empty topic
      set_filter_text("++/#");
      load_filter(6'd4);
      queue_text("ab/c");
      queue_end();
      queue_text("ab/");
      queue_end();
      queue_text("$a/b");
      queue_end();
      queue_end();
      wait_idle();

      // Plus reached after the last topic character
      set_filter_text("a/+");
      load_filter(6'd3);
      queue_text("a/");
      queue_end();
      wait_idle();

      // All-ones filter with an oversized length
      write_reg(REG_CHARS_A, '1);
      write_reg(REG_CHARS_B, '1);
      write_reg(REG_CHARS_C, '1);
      write_reg(REG_CHARS_D, '1);
      write_reg(REG_LENGTH, 64'd63);
      queue_byte(8'hFF);
      queue_end();
      wait_idle();

      // Zero bytes as ordinary characters, then a length change mid-topic
      set_filter_text("");
      flt_bytes[1] = CH_PLUS;
      load_filter(6'd2);
      queue_byte(8'h00);
      queue_byte(CH_PLUS);
      queue_end();
      queue_byte(8'h00);
      wait_idle();
      write_reg(REG_LENGTH, 64'd0);
      queue_end();
      wait_idle();

      // Random phases under different idle patterns
      run_phase(0, 0, 130);
      run_phase(77, 0, 130);
      run_phase(0, 77, 130);
      run_phase(33, 33, 130);

      // Long output stall while short topics keep coming
      @(posedge clock);
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      hold_req       <= 1'b1;
      build_filter();
      repeat (70) begin
         repeat ($urandom_range(0, 2)) queue_byte(pick_char());
         queue_end();
      end
      wait_idle();

      $display("Checked %0d verdicts over %0d topics (%0d items accepted).",
               results_checked, topics_sent, items_accepted);
      $display("Filter loads: %0d; idle patterns and one 300-cycle output stall exercised.",
               filter_loads);
      if (error_count == 0) begin
         $display("topic_filter_matcher verification clean");
      end else begin
         $display("topic_filter_matcher verification failed");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/tfm_pkg.sv
hw/rtl/tfm_step.sv
hw/rtl/topic_filter_matcher.sv
hw/rtl/tfm_checker.sv
dv/testbench.sv
